@@ rtl/core/pidaw_pkg.sv @@
package pidaw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_BOUND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_BOUND = 3'd4;

    localparam logic [23:0] BOUND_RESET = 24'd25600;

    localparam logic signed [16:0] DECAY_NUM   = 17'sd62259;
    localparam int                 DECAY_SHIFT = 16;

    typedef logic [1:0] t_mul_sel;

    localparam t_mul_sel MUL_P   = 2'd0;
    localparam t_mul_sel MUL_I   = 2'd1;
    localparam t_mul_sel MUL_D   = 2'd2;
    localparam t_mul_sel MUL_DEC = 2'd3;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [23:0]        integral_bound;
        logic [23:0]        drive_bound;
    } t_cfg;

    typedef struct packed {
        logic     load_err;
        logic     clear;
        t_mul_sel mul_sel;
        logic     load_prop;
        logic     load_asum;
        logic     load_deriv;
        logic     load_acc;
        logic     load_sum;
        logic     load_out;
    } t_cmd;

endpackage

@@ rtl/core/pidaw_cfg.sv @@
module pidaw_cfg
    import pidaw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN_P:      n_cfg.gain_p         = $signed(i_cfg_data[15:0]);
                CFG_GAIN_I:      n_cfg.gain_i         = $signed(i_cfg_data[15:0]);
                CFG_GAIN_D:      n_cfg.gain_d         = $signed(i_cfg_data[15:0]);
                CFG_INTEG_BOUND: n_cfg.integral_bound = i_cfg_data;
                CFG_DRIVE_BOUND: n_cfg.drive_bound    = i_cfg_data;
                default:         n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.integral_bound <= BOUND_RESET;
            r_cfg.drive_bound    <= BOUND_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/pidaw_ctrl.sv @@
module pidaw_ctrl
    import pidaw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_kind,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL_P = 3'd1;
    localparam logic [2:0] S_MUL_I = 3'd2;
    localparam logic [2:0] S_MUL_D = 3'd3;
    localparam logic [2:0] S_DECAY = 3'd4;
    localparam logic [2:0] S_INTEG = 3'd5;
    localparam logic [2:0] S_SUM   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_beat;
    t_cmd       cmd;

    assign o_ready = (r_state == S_IDLE);
    assign in_beat = i_valid && o_ready;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        cmd.mul_sel = MUL_P;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    cmd.load_err = !i_kind;
                    cmd.clear    = i_kind;
                    n_state      = i_kind ? S_OUT : S_MUL_P;
                end
            end
            S_MUL_P: begin
                cmd.mul_sel = MUL_P;
                n_state     = S_MUL_I;
            end
            S_MUL_I: begin
                cmd.mul_sel   = MUL_I;
                cmd.load_prop = 1'b1;
                n_state       = S_MUL_D;
            end
            S_MUL_D: begin
                cmd.mul_sel   = MUL_D;
                cmd.load_asum = 1'b1;
                n_state       = S_DECAY;
            end
            S_DECAY: begin
                cmd.mul_sel    = MUL_DEC;
                cmd.load_deriv = 1'b1;
                n_state        = S_INTEG;
            end
            S_INTEG: begin
                cmd.load_acc = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                cmd.load_sum = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                cmd.load_out = !r_out_valid || i_ready;
                if (cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

`ifndef SYNTHESIS
    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && !i_kind) |=> (r_state == S_MUL_P))
        else $error("compute beat did not start the multiply sequence");

    a_clear_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_kind) |=> (r_state == S_OUT))
        else $error("clear beat did not go straight to output");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> r_out_valid)
        else $error("result loaded without valid");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_out_valid && !i_ready) |=> (r_state == S_OUT))
        else $error("left output state while result still pending");

    a_integ_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> ($past(r_state) == S_INTEG))
        else $error("sum stage reached without integral update");
`endif

endmodule

@@ rtl/core/pidaw_dp.sv @@
module pidaw_dp
    import pidaw_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_cfg               i_cfg,
    input  logic signed [15:0] i_target,
    input  logic signed [15:0] i_measured,
    output logic signed [24:0] o_drive,
    output logic signed [24:0] o_prop_term,
    output logic signed [24:0] o_integ_term,
    output logic signed [25:0] o_deriv_term
);

    localparam int TERM_W = 33 - FRAC_BITS;
    localparam int DT_W   = 34 - FRAC_BITS;
    localparam int AS_W   = ((TERM_W > 25) ? TERM_W : 25) + 1;
    localparam int MA_W   = (AS_W > 18) ? AS_W : 18;
    localparam int PR_W   = MA_W + 17;
    localparam int MX_W   = (DT_W > 25) ? DT_W : 25;
    localparam int SUM_W  = MX_W + 2;
    localparam logic signed [17:0] ONE = 18'(1 << FRAC_BITS);

    logic signed [16:0]       r_err;
    logic signed [17:0]       r_derr;
    logic signed [16:0]       r_last_err;
    logic signed [PR_W-1:0]   r_prod;
    logic signed [TERM_W-1:0] r_prop;
    logic signed [AS_W-1:0]   r_asum;
    logic signed [DT_W-1:0]   r_deriv;
    logic signed [24:0]       r_acc;
    logic signed [SUM_W-1:0]  r_sum;

    logic signed [16:0]       err_c;
    logic signed [17:0]       derr_c;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [16:0]       mul_b;
    logic signed [PR_W-1:0]   prod_sh;
    logic signed [PR_W-1:0]   dec_sh;
    logic signed [TERM_W-1:0] term_pi;
    logic signed [DT_W-1:0]   term_d;
    logic signed [AS_W-1:0]   asum_c;
    logic signed [AS_W-1:0]   dec_v;
    logic signed [AS_W-1:0]   acc_pre;
    logic signed [AS_W-1:0]   bnd_i;
    logic signed [AS_W-1:0]   acc_cl;
    logic signed [17:0]       err_x;
    logic                     window;
    logic signed [SUM_W-1:0]  prop_x;
    logic signed [SUM_W-1:0]  acc_x;
    logic signed [SUM_W-1:0]  deriv_x;
    logic signed [SUM_W-1:0]  bnd_d;
    logic signed [SUM_W-1:0]  drv_cl;

    assign err_c  = 17'(i_measured) - 17'(i_target);
    assign derr_c = 18'(err_c) - 18'(r_last_err);

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_P: begin
                mul_a = MA_W'(r_err);
                mul_b = 17'(i_cfg.gain_p);
            end
            MUL_I: begin
                mul_a = MA_W'(r_err);
                mul_b = 17'(i_cfg.gain_i);
            end
            MUL_D: begin
                mul_a = MA_W'(r_derr);
                mul_b = 17'(i_cfg.gain_d);
            end
            MUL_DEC: begin
                mul_a = MA_W'(r_asum);
                mul_b = DECAY_NUM;
            end
        endcase
    end

    assign prod_sh = r_prod >>> FRAC_BITS;
    assign dec_sh  = r_prod >>> DECAY_SHIFT;
    assign term_pi = $signed(prod_sh[TERM_W-1:0]);
    assign term_d  = $signed(prod_sh[DT_W-1:0]);
    assign dec_v   = $signed(dec_sh[AS_W-1:0]);
    assign asum_c  = AS_W'(r_acc) + AS_W'(term_pi);

    assign err_x   = 18'(r_err);
    assign window  = (err_x > -ONE) && (err_x < ONE);
    assign acc_pre = window ? dec_v : r_asum;
    assign bnd_i   = AS_W'($signed({1'b0, i_cfg.integral_bound}));

    always_comb begin
        priority if (acc_pre > bnd_i) begin
            acc_cl = bnd_i;
        end else if (acc_pre < -bnd_i) begin
            acc_cl = -bnd_i;
        end else begin
            acc_cl = acc_pre;
        end
    end

    assign prop_x  = SUM_W'(r_prop);
    assign acc_x   = SUM_W'(r_acc);
    assign deriv_x = SUM_W'(r_deriv);
    assign bnd_d   = SUM_W'($signed({1'b0, i_cfg.drive_bound}));

    always_comb begin
        priority if (r_sum > bnd_d) begin
            drv_cl = bnd_d;
        end else if (r_sum < -bnd_d) begin
            drv_cl = -bnd_d;
        end else begin
            drv_cl = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_last_err <= '0;
        end else if (i_cmd.clear) begin
            r_acc      <= '0;
            r_last_err <= '0;
        end else if (i_cmd.load_acc) begin
            r_acc      <= $signed(acc_cl[24:0]);
            r_last_err <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.load_err) begin
            r_err  <= err_c;
            r_derr <= derr_c;
        end
        if (i_cmd.clear) begin
            r_prop  <= '0;
            r_deriv <= '0;
            r_sum   <= '0;
        end else begin
            if (i_cmd.load_prop) begin
                r_prop <= term_pi;
            end
            if (i_cmd.load_asum) begin
                r_asum <= asum_c;
            end
            if (i_cmd.load_deriv) begin
                r_deriv <= term_d;
            end
            if (i_cmd.load_sum) begin
                r_sum <= prop_x + acc_x + deriv_x;
            end
        end
        if (i_cmd.load_out) begin
            o_drive      <= $signed(drv_cl[24:0]);
            o_prop_term  <= $signed(prop_x[24:0]);
            o_integ_term <= r_acc;
            o_deriv_term <= $signed(deriv_x[25:0]);
        end
    end

endmodule

@@ rtl/core/pid_controller_antiwindup.sv @@
// PID step with integral clamp, integral decay inside one unit of error and output
// clamp, signed fixed point with FRAC_BITS fraction bits. In a compute item the four
// products (proportional, integral, derivative, decay) go in turn through one registered
// multiplier, followed by the integral clamp, the three-term sum and the output clamp.
// A clear item goes from idle straight to the output state. The result is held in an
// output register until taken; no input beat is taken while an item is in progress, only
// once its result is loaded there. Configuration writes are taken on every cycle.
module pid_controller_antiwindup
    import pidaw_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_kind,
    input  logic signed [15:0]    i_target,
    input  logic signed [15:0]    i_measured,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [24:0]    o_drive,
    output logic signed [24:0]    o_prop_term,
    output logic signed [24:0]    o_integ_term,
    output logic signed [25:0]    o_deriv_term,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_cfg cfg;

    assign o_cfg_ready = 1'b1;

    pidaw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pidaw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    pidaw_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg        (cfg),
        .i_target     (i_target),
        .i_measured   (i_measured),
        .o_drive      (o_drive),
        .o_prop_term  (o_prop_term),
        .o_integ_term (o_integ_term),
        .o_deriv_term (o_deriv_term)
    );

endmodule

@@ test/tb_pid_controller_antiwindup.sv @@
`timescale 1ns / 100ps

module tb_pid_controller_antiwindup;
    import pidaw_pkg::*;

    localparam int FRAC       = 8;
    localparam int LIMIT      = 400000;
    localparam int PHASE_ITEMS = 213;

    typedef struct {
        logic signed [24:0] drive;
        logic signed [24:0] prop;
        logic signed [24:0] integ;
        logic signed [25:0] deriv;
    } t_pid_out;

    class pid_law;
        longint   kp, ki, kd, ibound, dbound;
        longint   acc, prev_err;
        int       mismatches;
        t_pid_out due_outputs[$];

        function new();
            kp = 0;
            ki = 0;
            kd = 0;
            ibound = BOUND_RESET;
            dbound = BOUND_RESET;
            acc = 0;
            prev_err = 0;
            mismatches = 0;
        endfunction

        function longint clamp(longint v, longint b);
            if (v > b) return b;
            if (v < -b) return -b;
            return v;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            logic signed [15:0] g;
            g = data[15:0];
            case (idx)
                CFG_GAIN_P:      kp = g;
                CFG_GAIN_I:      ki = g;
                CFG_GAIN_D:      kd = g;
                CFG_INTEG_BOUND: ibound = data;
                CFG_DRIVE_BOUND: dbound = data;
                default: ;
            endcase
        endfunction

        function void log_beat(logic kind, logic signed [15:0] tgt, logic signed [15:0] meas);
            longint   err, prop, deriv, sum;
            t_pid_out res;
            if (kind) begin
                acc = 0;
                prev_err = 0;
                res = '{drive: '0, prop: '0, integ: '0, deriv: '0};
            end else begin
                err = longint'(meas) - longint'(tgt);
                prop = (kp * err) >>> FRAC;
                acc = acc + ((ki * err) >>> FRAC);
                if (err > -(64'sd1 << FRAC) && err < (64'sd1 << FRAC))
                    acc = (acc * longint'(DECAY_NUM)) >>> DECAY_SHIFT;
                acc = clamp(acc, ibound);
                deriv = (kd * (err - prev_err)) >>> FRAC;
                prev_err = err;
                sum = clamp(prop + acc + deriv, dbound);
                res.drive = 25'(sum);
                res.prop  = 25'(prop);
                res.integ = 25'(acc);
                res.deriv = 26'(deriv);
            end
            due_outputs.push_back(res);
        endfunction

        function void match_beat(logic signed [24:0] drive, logic signed [24:0] prop,
                                 logic signed [24:0] integ, logic signed [25:0] deriv);
            t_pid_out e;
            if (due_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing pending: drive %0d", drive);
                return;
            end
            e = due_outputs.pop_front();
            if (e.drive !== drive || e.prop !== prop || e.integ !== integ
                    || e.deriv !== deriv) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("drive %0d/%0d prop %0d/%0d integ %0d/%0d deriv %0d/%0d",
                             e.drive, drive, e.prop, prop, e.integ, integ, e.deriv, deriv);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_kind;
    logic signed [15:0]    i_target;
    logic signed [15:0]    i_measured;
    logic                  o_valid;
    logic                  i_ready;
    logic signed [24:0]    o_drive;
    logic signed [24:0]    o_prop_term;
    logic signed [24:0]    o_integ_term;
    logic signed [25:0]    o_deriv_term;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pid_law law = new();
    int     send_idle;
    int     recv_idle;
    int     cycles;

    pid_controller_antiwindup #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_kind(i_kind),
        .i_target(i_target),
        .i_measured(i_measured),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_drive(o_drive),
        .o_prop_term(o_prop_term),
        .o_integ_term(o_integ_term),
        .o_deriv_term(o_deriv_term),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            law.match_beat(o_drive, o_prop_term, o_integ_term, o_deriv_term);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("pid_controller_antiwindup: mismatch");
            $finish;
        end
    end

    function automatic logic signed [15:0] sat16(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    task automatic send_step(input logic kind, input logic signed [15:0] tgt,
                             input logic signed [15:0] meas);
        while ($urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            i_target = 16'($urandom);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_kind = kind;
        i_target = tgt;
        i_measured = meas;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        law.log_beat(kind, tgt, meas);
    endtask

    // hold off until every pending result has been taken
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (law.due_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        law.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [23:0] kp, input logic [23:0] ki,
                             input logic [23:0] kd, input logic [23:0] ib,
                             input logic [23:0] db);
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
        write_reg(CFG_INTEG_BOUND, ib);
        write_reg(CFG_DRIVE_BOUND, db);
    endtask

    task automatic setup_phase(input int ph);
        case (ph)
            0: write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                         24'($urandom));
            1: write_all(24'hFF7FFF, 24'h007FFF, 24'hA57FFF, 24'hFFFFFF, 24'hFFFFFF);
            2: write_all(24'h008000, 24'hFF8000, 24'h5A8000, 24'h000000, 24'h000000);
            3: write_all(24'($urandom_range(1024) - 512), 24'($urandom_range(1024) - 512),
                         24'($urandom_range(1024) - 512), 24'($urandom_range(65535)),
                         24'($urandom_range(65535)));
            4: write_all(24'($urandom), 24'($urandom), 24'($urandom),
                         24'($urandom_range(4096)), 24'hFFFFFF);
            default: write_all(24'h000000, 24'($urandom), 24'($urandom), 24'($urandom),
                               24'($urandom_range(100000)));
        endcase
    endtask

    task automatic random_step();
        int                 r;
        int                 t;
        logic signed [15:0] ext [4];
        ext = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
        r = $urandom_range(99);
        t = $signed(16'($urandom));
        if (r < 5)
            send_step(1'b1, 16'($urandom), 16'($urandom));
        else if (r < 30)
            send_step(1'b0, 16'($urandom), 16'($urandom));
        else if (r < 60)
            send_step(1'b0, 16'(t), sat16(t + $urandom_range(600) - 300));
        else if (r < 70)
            send_step(1'b0, ext[2'($urandom_range(3))], ext[2'($urandom_range(3))]);
        else if (r < 85)
            send_step(1'b0, 16'(t), sat16(t + ($urandom_range(1) ? 256 : -256)
                                    + ($urandom_range(1) ? 0 : ($urandom_range(1) ? 1 : -1))));
        else
            send_step(1'b0, 16'(t), sat16(t + $urandom_range(40000) - 20000));
    endtask

    initial begin
        int ph;
        int n;
        cycles = 0;
        send_idle = 13;
        recv_idle = 86;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = 1'b0;
        i_target = '0;
        i_measured = '0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_all(24'h000180, 24'h000040, 24'h000100, BOUND_RESET, BOUND_RESET);
        send_step(1'b1, 16'sh0000, 16'sh0000);
        send_step(1'b0, 16'sh0000, 16'sh0000);
        send_step(1'b0, 16'sh8000, 16'sh7FFF);
        send_step(1'b0, 16'sh7FFF, 16'sh8000);
        send_step(1'b0, 16'sh0000, 16'sh0100);
        send_step(1'b0, 16'sh0000, -16'sh0100);
        send_step(1'b0, 16'sh0000, 16'sh00FF);
        send_step(1'b0, 16'sh0000, -16'sh00FF);
        send_step(1'b0, 16'sh0064, 16'sh0064);
        send_step(1'b1, 16'shFFFF, 16'shFFFF);
        send_step(1'b0, 16'sh8000, 16'sh8000);
        send_step(1'b0, 16'sh7FFF, 16'sh7FFF);
        drain();

        write_all(24'h007FFF, 24'h007FFF, 24'h008000, 24'hFFFFFF, 24'hFFFFFF);
        repeat (4) send_step(1'b0, 16'sh8000, 16'sh7FFF);
        send_step(1'b0, 16'sh7FFF, 16'sh8000);
        send_step(1'b0, 16'sh1000, 16'sh1000);
        drain();

        // bound lowered under the live integral
        write_reg(CFG_INTEG_BOUND, 24'd1000);
        write_reg(CFG_DRIVE_BOUND, 24'd500);
        send_step(1'b0, 16'sh0000, 16'sh0000);
        send_step(1'b0, 16'sh0000, 16'sh4E20);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                send_idle = 13;
                recv_idle = 86;
            end else if (ph < 4) begin
                send_idle = 86;
                recv_idle = 13;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            setup_phase(ph);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    drain();
                random_step();
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (law.mismatches == 0 && law.due_outputs.size() == 0)
            $display("pid_controller_antiwindup: match");
        else
            $display("pid_controller_antiwindup: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/pidaw_pkg.sv
rtl/core/pidaw_cfg.sv
rtl/core/pidaw_ctrl.sv
rtl/core/pidaw_dp.sv
rtl/core/pid_controller_antiwindup.sv
test/tb_pid_controller_antiwindup.sv
